/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ssi_pkg.sv */
// Types, constants and Q16.16 arithmetic helpers for the segment crossing block.
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

    localparam int QW        = 32;
    localparam int QF        = 16;
    localparam int DIV_NB    = QW + QF;
    localparam int DIV_LAT   = DIV_NB + 2;
    localparam int CFG_IDX_W = 4;

    typedef logic signed [QW-1:0]   q_t;
    typedef logic signed [2*QW-1:0] prod_t;

    localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_A_SX  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_SY  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_EX  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A_EY  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A_SVX = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A_SVY = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_A_EVX = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_A_EVY = 4'd7;

    typedef enum logic [1:0] {
        MODE_MISS,
        MODE_GEN,
        MODE_AV,
        MODE_BV
    } cross_mode_t;

    typedef struct packed {
        q_t sx;
        q_t sy;
        q_t ex;
        q_t ey;
        q_t svx;
        q_t svy;
        q_t evx;
        q_t evy;
    } seg_pts_t;

    typedef struct packed {
        q_t minx;
        q_t maxx;
        q_t miny;
        q_t maxy;
    } seg_box_t;

    typedef struct packed {
        logic     vert;
        q_t       slope;
        q_t       off;
        q_t       slope_p;
        q_t       off_p;
        seg_box_t box;
    } seg_form_t;

    function automatic q_t sat33(input logic signed [QW:0] v);
        q_t r;
        if (v > $signed({1'b0, Q_MAX})) r = Q_MAX;
        else if (v < $signed({1'b1, Q_MIN})) r = Q_MIN;
        else r = v[QW-1:0];
        return r;
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        return sat33({a[QW-1], a} + {b[QW-1], b});
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return sat33({a[QW-1], a} - {b[QW-1], b});
    endfunction

    function automatic prod_t mul32(input q_t a, input q_t b);
        prod_t r;
        r = a * b;
        return r;
    endfunction

    // Product back to Q16.16: truncate toward zero, then saturate.
    function automatic q_t qmul_fin(input prod_t p);
        prod_t t;
        q_t    r;
        t = p[2*QW-1] ? p + prod_t'((1 << QF) - 1) : p;
        t = t >>> QF;
        if (t > prod_t'(Q_MAX)) r = Q_MAX;
        else if (t < prod_t'(Q_MIN)) r = Q_MIN;
        else r = t[QW-1:0];
        return r;
    endfunction

    function automatic logic in_box(input seg_box_t bx, input q_t x, input q_t y);
        logic signed [QW:0] xe, ye, lx, hx, ly, hy;
        xe = {x[QW-1], x};
        ye = {y[QW-1], y};
        lx = {bx.minx[QW-1], bx.minx};
        hx = {bx.maxx[QW-1], bx.maxx};
        ly = {bx.miny[QW-1], bx.miny};
        hy = {bx.maxy[QW-1], bx.maxy};
        return (lx - 33'sd1 <= xe) && (xe <= hx + 33'sd1) &&
               (ly - 33'sd1 <= ye) && (ye <= hy + 33'sd1);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ssi_div.sv */
// Pipelined Q16.16 divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ssi_div
    import ssi_pkg::*;
#(
    parameter int SW = 1
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire q_t            num,
    input  wire q_t            den,
    input  wire logic [SW-1:0] side_in,
    output logic               vld_out,
    output q_t                 quo,
    output logic [SW-1:0]      side_out
);

    // Index 0 holds the prepared operands; index k+1 holds the result of step k.
    logic              vld_reg  [DIV_NB+1];
    logic [QW-1:0]     rem_reg  [DIV_NB+1];
    logic [DIV_NB-1:0] q_reg    [DIV_NB+1];
    logic [DIV_NB-1:0] n_reg    [DIV_NB+1];
    logic [QW-1:0]     d_reg    [DIV_NB+1];
    logic              neg_reg  [DIV_NB+1];
    logic [SW-1:0]     side_reg [DIV_NB+1];

    logic [QW-1:0]     n_mag;
    logic [QW-1:0]     d_mag;
    logic              out_vld_reg;
    q_t                quo_reg;
    q_t                quo_next;
    logic [SW-1:0]     out_side_reg;
    logic [DIV_NB-1:0] qm;

    always_comb
    begin
        n_mag = num[QW-1] ? (~num + 1'b1) : num;
        d_mag = den[QW-1] ? (~den + 1'b1) : den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            q_reg[0]    <= '0;
            n_reg[0]    <= {n_mag, {QF{1'b0}}};
            d_reg[0]    <= d_mag;
            neg_reg[0]  <= num[QW-1] ^ den[QW-1];
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < DIV_NB; k++)
    begin : g_step
        logic [QW:0]       trial;
        logic              ge;
        logic [QW-1:0]     rem_next;
        logic [DIV_NB-1:0] q_next;

        always_comb
        begin
            trial    = {rem_reg[k], n_reg[k][DIV_NB-1-k]};
            ge       = trial >= {1'b0, d_reg[k]};
            rem_next = ge ? QW'(trial - {1'b0, d_reg[k]}) : trial[QW-1:0];
            q_next   = q_reg[k];
            q_next[DIV_NB-1-k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                q_reg[k+1]    <= q_next;
                n_reg[k+1]    <= n_reg[k];
                d_reg[k+1]    <= d_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // A zero divisor gives zero; otherwise restore the sign and saturate.
    always_comb
    begin
        qm = q_reg[DIV_NB];
        if (d_reg[DIV_NB] == '0)
            quo_next = '0;
        else if (neg_reg[DIV_NB])
            quo_next = (qm > {{(DIV_NB-QW){1'b0}}, 1'b1, {(QW-1){1'b0}}}) ?
                       Q_MIN : q_t'(~qm[QW-1:0] + 1'b1);
        else
            quo_next = (qm > {{(DIV_NB-QW+1){1'b0}}, {(QW-1){1'b1}}}) ?
                       Q_MAX : q_t'(qm[QW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[DIV_NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg      <= quo_next;
            out_side_reg <= side_reg[DIV_NB];
        end
    end

    assign vld_out  = out_vld_reg;
    assign quo      = quo_reg;
    assign side_out = out_side_reg;

    `ASSERT_NXT(a_div_zero, en && vld_reg[DIV_NB] && d_reg[DIV_NB] == '0, quo_reg == '0, "zero divisor must give a zero quotient")

endmodule

`default_nettype wire

/* hw/rtl/ssi_seg.sv */
// Slope-offset form of one moving segment, with slope and offset derivatives.
`timescale 1ns / 1ps
`default_nettype none

module ssi_seg
    import ssi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     vld_in,
    input  wire seg_pts_t pts,
    output logic          vld_out,
    output seg_form_t     form
);

    typedef struct packed {
        q_t       dx;
        q_t       dvx;
        q_t       dvy;
        q_t       x1;
        q_t       y1;
        q_t       vx1;
        q_t       vy1;
        seg_box_t box;
    } d1_side_t;

    typedef struct packed {
        q_t       slope;
        q_t       off;
        q_t       dx;
        q_t       x1;
        q_t       vx1;
        q_t       vy1;
        seg_box_t box;
    } d2_side_t;

    logic      s1_vld_reg;
    q_t        s1_dy_reg;
    d1_side_t  s1_reg;
    d1_side_t  s1_next;

    logic      d1_vld;
    q_t        d1_slope;
    d1_side_t  d1_side;

    logic      s2_vld_reg;
    q_t        s2_slope_reg;
    prod_t     s2_pa_reg;
    prod_t     s2_pb_reg;
    d1_side_t  s2_reg;

    logic      s3_vld_reg;
    q_t        s3_t_reg;
    d2_side_t  s3_reg;
    d2_side_t  s3_next;

    logic      d2_vld;
    q_t        d2_slope_p;
    d2_side_t  d2_side;

    logic      s4_vld_reg;
    q_t        s4_slope_p_reg;
    prod_t     s4_pc_reg;
    prod_t     s4_pd_reg;
    d2_side_t  s4_reg;

    logic      out_vld_reg;
    seg_form_t form_reg;
    seg_form_t form_next;

    always_comb
    begin
        s1_next.dx       = qsub(pts.ex, pts.sx);
        s1_next.dvx      = qsub(pts.evx, pts.svx);
        s1_next.dvy      = qsub(pts.evy, pts.svy);
        s1_next.x1       = pts.sx;
        s1_next.y1       = pts.sy;
        s1_next.vx1      = pts.svx;
        s1_next.vy1      = pts.svy;
        s1_next.box.minx = (pts.sx < pts.ex) ? pts.sx : pts.ex;
        s1_next.box.maxx = (pts.sx < pts.ex) ? pts.ex : pts.sx;
        s1_next.box.miny = (pts.sy < pts.ey) ? pts.sy : pts.ey;
        s1_next.box.maxy = (pts.sy < pts.ey) ? pts.ey : pts.sy;
    end

    ssi_div #(
        .SW ($bits(d1_side_t))
    ) u_div_slope (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s1_vld_reg),
        .num      (s1_dy_reg),
        .den      (s1_reg.dx),
        .side_in  (s1_reg),
        .vld_out  (d1_vld),
        .quo      (d1_slope),
        .side_out (d1_side)
    );

    always_comb
    begin
        s3_next.slope = s2_slope_reg;
        s3_next.off   = qsub(s2_reg.y1, qmul_fin(s2_pb_reg));
        s3_next.dx    = s2_reg.dx;
        s3_next.x1    = s2_reg.x1;
        s3_next.vx1   = s2_reg.vx1;
        s3_next.vy1   = s2_reg.vy1;
        s3_next.box   = s2_reg.box;
    end

    ssi_div #(
        .SW ($bits(d2_side_t))
    ) u_div_slope_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s3_vld_reg),
        .num      (s3_t_reg),
        .den      (s3_reg.dx),
        .side_in  (s3_reg),
        .vld_out  (d2_vld),
        .quo      (d2_slope_p),
        .side_out (d2_side)
    );

    // A vertical segment is described by x = offset; the divider already
    // returns zero slopes for a zero dx.
    always_comb
    begin
        form_next.vert    = (s4_reg.dx == '0);
        form_next.slope   = form_next.vert ? '0 : s4_reg.slope;
        form_next.slope_p = form_next.vert ? '0 : s4_slope_p_reg;
        form_next.off     = form_next.vert ? s4_reg.x1 : s4_reg.off;
        form_next.off_p   = form_next.vert ? s4_reg.vx1 :
                            qsub(qsub(s4_reg.vy1, qmul_fin(s4_pc_reg)),
                                 qmul_fin(s4_pd_reg));
        form_next.box     = s4_reg.box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= vld_in;
            s2_vld_reg  <= d1_vld;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= d2_vld;
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dy_reg      <= qsub(pts.ey, pts.sy);
            s1_reg         <= s1_next;
            s2_slope_reg   <= d1_slope;
            s2_pa_reg      <= mul32(d1_slope, d1_side.dvx);
            s2_pb_reg      <= mul32(d1_slope, d1_side.x1);
            s2_reg         <= d1_side;
            s3_t_reg       <= qsub(s2_reg.dvy, qmul_fin(s2_pa_reg));
            s3_reg         <= s3_next;
            s4_slope_p_reg <= d2_slope_p;
            s4_pc_reg      <= mul32(d2_slope_p, d2_side.x1);
            s4_pd_reg      <= mul32(d2_side.slope, d2_side.vx1);
            s4_reg         <= d2_side;
            form_reg       <= form_next;
        end
    end

    assign vld_out = out_vld_reg;
    assign form    = form_reg;

endmodule

`default_nettype wire

/* hw/rtl/segment_segment_intersection.sv */
// Top level of the moving segment crossing block.
// Segment A (two endpoints and their velocities, Q16.16) sits in eight
// registers written through the cfg port; the user must write them only
// while the block is idle, which the block itself does not enforce. Each
// input beat carries a segment B and yields exactly one output beat with the
// hit flag, the crossing point and its velocity (all zero on a miss). The
// block is a fully pipelined datapath that takes one beat per clock while
// the output is not stalled. Four Q16.16 divisions run in series (segment
// slope, slope derivative, crossing x and crossing x velocity), each
// resolving one of its 48 quotient bits per stage. A stall on the output
// holds the whole pipeline in place, so no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module segment_segment_intersection
    import ssi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire q_t                   cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire q_t                   b_start_x,
    input  wire q_t                   b_start_y,
    input  wire q_t                   b_end_x,
    input  wire q_t                   b_end_y,
    input  wire q_t                   b_start_vx,
    input  wire q_t                   b_start_vy,
    input  wire q_t                   b_end_vx,
    input  wire q_t                   b_end_vy,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      hit,
    output q_t                        cross_x,
    output q_t                        cross_y,
    output q_t                        cross_vx,
    output q_t                        cross_vy
);

    typedef struct packed {
        cross_mode_t mode;
        q_t          ds;
        q_t          dsp;
        q_t          dop;
        q_t          s_slope;
        q_t          s_off;
        q_t          s_slope_p;
        q_t          s_off_p;
        q_t          v_off;
        q_t          v_off_p;
        seg_box_t    box_a;
        seg_box_t    box_b;
    } t1_t;

    typedef struct packed {
        q_t  x_g;
        t1_t c;
    } t3_t;

    typedef struct packed {
        logic     miss;
        q_t       x;
        q_t       vx;
        q_t       slope;
        q_t       off;
        q_t       slope_p;
        q_t       off_p;
        seg_box_t box_a;
        seg_box_t box_b;
    } t4_t;

    logic      adv;
    seg_pts_t  a_pts_reg;
    seg_pts_t  b_pts;

    seg_form_t fa;
    seg_form_t fb;
    logic      fa_vld;
    logic      fb_vld;

    logic      t1_vld_reg;
    q_t        t1_dof_reg;
    t1_t       t1_reg;
    t1_t       t1_next;

    logic      d3_vld;
    q_t        d3_x;
    t1_t       d3_side;

    logic      t2_vld_reg;
    q_t        t2_x_reg;
    prod_t     t2_p_reg;
    t1_t       t2_reg;

    logic      t3_vld_reg;
    q_t        t3_t_reg;
    t3_t       t3_reg;

    logic      d4_vld;
    q_t        d4_vx;
    t3_t       d4_side;

    logic      t4_vld_reg;
    t4_t       t4_reg;
    t4_t       t4_next;

    logic      t5_vld_reg;
    prod_t     t5_py_reg;
    prod_t     t5_pv1_reg;
    prod_t     t5_pv2_reg;
    t4_t       t5_reg;

    logic      t6_vld_reg;
    q_t        t6_y_reg;
    q_t        t6_vy_reg;
    t4_t       t6_reg;

    logic      out_valid_reg;
    logic      hit_reg;
    logic      hit_next;
    q_t        cross_x_reg;
    q_t        cross_y_reg;
    q_t        cross_vx_reg;
    q_t        cross_vy_reg;

    // The whole pipeline moves together unless a finished beat is held.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pts_reg <= seg_pts_t'{ex: q_t'(1 << QF), default: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_A_SX:  a_pts_reg.sx  <= cfg_data;
                REG_A_SY:  a_pts_reg.sy  <= cfg_data;
                REG_A_EX:  a_pts_reg.ex  <= cfg_data;
                REG_A_EY:  a_pts_reg.ey  <= cfg_data;
                REG_A_SVX: a_pts_reg.svx <= cfg_data;
                REG_A_SVY: a_pts_reg.svy <= cfg_data;
                REG_A_EVX: a_pts_reg.evx <= cfg_data;
                REG_A_EVY: a_pts_reg.evy <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        b_pts.sx  = b_start_x;
        b_pts.sy  = b_start_y;
        b_pts.ex  = b_end_x;
        b_pts.ey  = b_end_y;
        b_pts.svx = b_start_vx;
        b_pts.svy = b_start_vy;
        b_pts.evx = b_end_vx;
        b_pts.evy = b_end_vy;
    end

    // Segment A is rebuilt alongside every beat; the user must hold its registers
    // still while any beat is in flight. The block itself does not enforce this.
    ssi_seg u_seg_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (in_valid),
        .pts     (a_pts_reg),
        .vld_out (fa_vld),
        .form    (fa)
    );

    ssi_seg u_seg_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (in_valid),
        .pts     (b_pts),
        .vld_out (fb_vld),
        .form    (fb)
    );

    // Pick the case. In the vertical cases the other segment supplies the
    // slope terms; in the general case segment A does.
    always_comb
    begin
        if (fa.vert && fb.vert)
            t1_next.mode = MODE_MISS;
        else if (fa.vert)
            t1_next.mode = MODE_AV;
        else if (fb.vert)
            t1_next.mode = MODE_BV;
        else if (fa.slope == fb.slope)
            t1_next.mode = MODE_MISS;
        else
            t1_next.mode = MODE_GEN;

        t1_next.ds        = qsub(fb.slope, fa.slope);
        t1_next.dsp       = qsub(fb.slope_p, fa.slope_p);
        t1_next.dop       = qsub(fa.off_p, fb.off_p);
        t1_next.s_slope   = fa.vert ? fb.slope : fa.slope;
        t1_next.s_off     = fa.vert ? fb.off : fa.off;
        t1_next.s_slope_p = fa.vert ? fb.slope_p : fa.slope_p;
        t1_next.s_off_p   = fa.vert ? fb.off_p : fa.off_p;
        t1_next.v_off     = fa.vert ? fa.off : fb.off;
        t1_next.v_off_p   = fa.vert ? fa.off_p : fb.off_p;
        t1_next.box_a     = fa.box;
        t1_next.box_b     = fb.box;
    end

    ssi_div #(
        .SW ($bits(t1_t))
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (t1_vld_reg),
        .num      (t1_dof_reg),
        .den      (t1_reg.ds),
        .side_in  (t1_reg),
        .vld_out  (d3_vld),
        .quo      (d3_x),
        .side_out (d3_side)
    );

    ssi_div #(
        .SW ($bits(t3_t))
    ) u_div_vx (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (t3_vld_reg),
        .num      (t3_t_reg),
        .den      (t3_reg.c.ds),
        .side_in  (t3_reg),
        .vld_out  (d4_vld),
        .quo      (d4_vx),
        .side_out (d4_side)
    );

    always_comb
    begin
        t4_next.miss    = (d4_side.c.mode == MODE_MISS);
        t4_next.x       = (d4_side.c.mode == MODE_GEN) ? d4_side.x_g : d4_side.c.v_off;
        t4_next.vx      = (d4_side.c.mode == MODE_GEN) ? d4_vx : d4_side.c.v_off_p;
        t4_next.slope   = d4_side.c.s_slope;
        t4_next.off     = d4_side.c.s_off;
        t4_next.slope_p = d4_side.c.s_slope_p;
        t4_next.off_p   = d4_side.c.s_off_p;
        t4_next.box_a   = d4_side.c.box_a;
        t4_next.box_b   = d4_side.c.box_b;
    end

    always_comb
    begin
        hit_next = !t6_reg.miss &&
                   in_box(t6_reg.box_a, t6_reg.x, t6_y_reg) &&
                   in_box(t6_reg.box_b, t6_reg.x, t6_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg    <= 1'b0;
            t2_vld_reg    <= 1'b0;
            t3_vld_reg    <= 1'b0;
            t4_vld_reg    <= 1'b0;
            t5_vld_reg    <= 1'b0;
            t6_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_vld_reg    <= fb_vld;
            t2_vld_reg    <= d3_vld;
            t3_vld_reg    <= t2_vld_reg;
            t4_vld_reg    <= d4_vld;
            t5_vld_reg    <= t4_vld_reg;
            t6_vld_reg    <= t5_vld_reg;
            out_valid_reg <= t6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_dof_reg   <= qsub(fa.off, fb.off);
            t1_reg       <= t1_next;
            t2_x_reg     <= d3_x;
            t2_p_reg     <= mul32(d3_x, d3_side.dsp);
            t2_reg       <= d3_side;
            t3_t_reg     <= qsub(t2_reg.dop, qmul_fin(t2_p_reg));
            t3_reg.x_g   <= t2_x_reg;
            t3_reg.c     <= t2_reg;
            t4_reg       <= t4_next;
            t5_py_reg    <= mul32(t4_reg.slope, t4_reg.x);
            t5_pv1_reg   <= mul32(t4_reg.slope_p, t4_reg.x);
            t5_pv2_reg   <= mul32(t4_reg.slope, t4_reg.vx);
            t5_reg       <= t4_reg;
            t6_y_reg     <= qadd(qmul_fin(t5_py_reg), t5_reg.off);
            t6_vy_reg    <= qadd(qadd(qmul_fin(t5_pv1_reg), qmul_fin(t5_pv2_reg)),
                                 t5_reg.off_p);
            t6_reg       <= t5_reg;
            hit_reg      <= hit_next;
            cross_x_reg  <= hit_next ? t6_reg.x : '0;
            cross_y_reg  <= hit_next ? t6_y_reg : '0;
            cross_vx_reg <= hit_next ? t6_reg.vx : '0;
            cross_vy_reg <= hit_next ? t6_vy_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;
    assign cross_vx  = cross_vx_reg;
    assign cross_vy  = cross_vy_reg;

    `ASSERT_IMP(a_miss_zero, out_valid_reg && !hit_reg, cross_x_reg == '0 && cross_y_reg == '0 && cross_vx_reg == '0 && cross_vy_reg == '0, "a miss must carry a zero payload")
    `ASSERT_NXT(a_t6_hold, t6_vld_reg && !adv, t6_vld_reg && $stable(t6_y_reg) && $stable(t6_vy_reg), "a stalled stage must keep its beat")
    `ASSERT_IMP(a_seg_lockstep, 1'b1, fa_vld == fb_vld, "both segment pipelines must carry the same beats")

endmodule

`default_nettype wire
